// File: hw/rtl/asec_pkg.sv
package asec_pkg;

    // shaping table
    localparam int unsigned TABLE_DEPTH = 1024;
    localparam int unsigned TBL_AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // field widths
    localparam int unsigned W_CMD       = 2;
    localparam int unsigned W_SAMPLE    = 12;
    localparam int unsigned W_LEVEL     = 10;
    localparam int unsigned W_TVAL      = 10;
    localparam int unsigned W_COEF      = 32;
    localparam int unsigned W_CFG_IDX   = 3;
    localparam int unsigned SHAPE_SHIFT = 2;

    // table address compare width: wide enough for the level and for the depth itself
    localparam int unsigned TBL_XW = ((TBL_AW > W_LEVEL) ? TBL_AW : W_LEVEL) + 1;

    // output scaling: y / 3270 toward zero, clamped to 0..4095
    localparam int unsigned SCALE_DIV   = 3270;
    localparam int unsigned DAC_MAX     = 4095;
    localparam int unsigned SAT_LIMIT   = (DAC_MAX + 1) * SCALE_DIV;
    localparam int unsigned W_SAT       = $clog2(SAT_LIMIT);
    localparam int unsigned RECIP_SHIFT = W_SAT + W_SAMPLE;
    localparam longint unsigned RECIP   =
        ((64'd1 << RECIP_SHIFT) + SCALE_DIV - 1) / SCALE_DIV;
    localparam int unsigned W_RECIP     = $clog2(RECIP + 1);
    localparam int unsigned W_PROD      = W_SAT + W_RECIP;

    // register stages from input to output
    localparam int unsigned PIPE_DEPTH  = 6;
    localparam int unsigned W_FLIGHT    = $clog2(PIPE_DEPTH + 1);

    typedef enum logic [W_CMD-1:0] {
        CMD_PROCESS    = 2'd0,
        CMD_TBL_WRITE  = 2'd1,
        CMD_PEAK_CLEAR = 2'd2
    } t_cmd;

    typedef enum logic [W_CFG_IDX-1:0] {
        CFG_DIST  = 3'd0,
        CFG_SHELV = 3'd1,
        CFG_B0    = 3'd2,
        CFG_B1    = 3'd3,
        CFG_B2    = 3'd4,
        CFG_A1    = 3'd5,
        CFG_A2    = 3'd6
    } t_cfg_reg;

    typedef struct packed {
        logic              distort;
        logic              shelv;
        logic [W_COEF-1:0] b0;
        logic [W_COEF-1:0] b1;
        logic [W_COEF-1:0] b2;
        logic [W_COEF-1:0] a1;
        logic [W_COEF-1:0] a2;
    } t_cfg;

    typedef struct packed {
        logic [W_CMD-1:0]    command;
        logic [W_SAMPLE-1:0] sample;
        logic [W_LEVEL-1:0]  table_index;
        logic [W_TVAL-1:0]   table_value;
    } t_item;

    typedef struct packed {
        logic                proc;
        logic                shelv;
        logic [W_SAMPLE-1:0] x;
        logic [W_LEVEL-1:0]  peak;
    } t_ctl;

    typedef struct packed {
        t_ctl              ctl;
        logic [W_COEF-1:0] p0;
        logic [W_COEF-1:0] p1;
        logic [W_COEF-1:0] p2;
    } t_front;

    typedef struct packed {
        t_ctl              ctl;
        logic [W_COEF-1:0] y;
    } t_fb;

endpackage

// File: hw/rtl/asec_if.sv
interface asec_in_if;
    import asec_pkg::*;

    logic                valid;
    logic                ready;
    logic [W_CMD-1:0]    command;
    logic [W_SAMPLE-1:0] sample;
    logic [W_LEVEL-1:0]  table_index;
    logic [W_TVAL-1:0]   table_value;

    modport source (output valid, output command, output sample, output table_index,
                    output table_value, input ready);
    modport sink   (input valid, input command, input sample, input table_index,
                    input table_value, output ready);
endinterface

interface asec_out_if;
    import asec_pkg::*;

    logic                valid;
    logic                ready;
    logic [W_SAMPLE-1:0] dac_value;
    logic [W_LEVEL-1:0]  peak_level;

    modport source (output valid, output dac_value, output peak_level, input ready);
    modport sink   (input valid, input dac_value, input peak_level, output ready);
endinterface

interface asec_cfg_if;
    import asec_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [W_CFG_IDX-1:0] index;
    logic [W_COEF-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/audio_sample_effect_chain_unit.sv
// A beat passes through the registers of stages A and B (front), C and D (biquad), then E and
// the output register (scale). Throughput: one beat per cycle while the output is not stalled;
// the recursive path is the a1 * y[n-1] multiply and subtract in the biquad loop stage, from r_y1 back to r_y1.
// Reset (synchronous, i_rst_n low): clears all valid flags, configuration,
// peak hold, filter history and the held DAC value. The shaping table is not cleared.
module audio_sample_effect_chain_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    asec_in_if.sink      i_in,
    asec_out_if.source   o_out,
    asec_cfg_if.sink     i_cfg
);
    import asec_pkg::*;

    t_cfg                r_cfg;
    logic [W_FLIGHT-1:0] r_flight;

    logic                w_cfg_acc;
    logic                w_hist_clr;
    logic                w_in_acc;
    logic                w_out_acc;
    t_item               w_item;

    logic                w_fr_valid;
    logic                w_fr_ready;
    t_front              w_fr_data;
    logic                w_bq_valid;
    logic                w_bq_ready;
    t_fb                 w_bq_data;

    assign i_cfg.ready = 1'b1;
    assign w_cfg_acc   = i_cfg.valid && i_cfg.ready;

    // any coefficient write restarts the filter
    assign w_hist_clr = w_cfg_acc &&
                        ((i_cfg.index == CFG_B0) || (i_cfg.index == CFG_B1) ||
                         (i_cfg.index == CFG_B2) || (i_cfg.index == CFG_A1) ||
                         (i_cfg.index == CFG_A2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_cfg_acc) begin
            unique case (i_cfg.index)
                CFG_DIST:  r_cfg.distort <= i_cfg.data[0];
                CFG_SHELV: r_cfg.shelv   <= i_cfg.data[0];
                CFG_B0:    r_cfg.b0      <= i_cfg.data;
                CFG_B1:    r_cfg.b1      <= i_cfg.data;
                CFG_B2:    r_cfg.b2      <= i_cfg.data;
                CFG_A1:    r_cfg.a1      <= i_cfg.data;
                CFG_A2:    r_cfg.a2      <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign w_item.command     = i_in.command;
    assign w_item.sample      = i_in.sample;
    assign w_item.table_index = i_in.table_index;
    assign w_item.table_value = i_in.table_value;

    asec_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_hist_clr (w_hist_clr),
        .i_valid    (i_in.valid),
        .o_ready    (i_in.ready),
        .i_item     (w_item),
        .o_valid    (w_fr_valid),
        .i_ready    (w_fr_ready),
        .o_data     (w_fr_data)
    );

    asec_biquad u_biquad (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_hist_clr (w_hist_clr),
        .i_valid    (w_fr_valid),
        .o_ready    (w_fr_ready),
        .i_data     (w_fr_data),
        .o_valid    (w_bq_valid),
        .i_ready    (w_bq_ready),
        .o_data     (w_bq_data)
    );

    asec_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_bq_valid),
        .o_ready (w_bq_ready),
        .i_data  (w_bq_data),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_dac   (o_out.dac_value),
        .o_peak  (o_out.peak_level)
    );

    // beats inside the pipeline
    assign w_in_acc  = i_in.valid && i_in.ready;
    assign w_out_acc = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flight <= '0;
        end else begin
            priority if (w_in_acc && !w_out_acc) begin
                r_flight <= r_flight + W_FLIGHT'(1);
            end else if (w_out_acc && !w_in_acc) begin
                r_flight <= r_flight - W_FLIGHT'(1);
            end else begin
                r_flight <= r_flight;
            end
        end
    end

    a_flight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flight <= W_FLIGHT'(PIPE_DEPTH))
        else $error("more beats in flight than pipeline stages");

    a_out_has_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (r_flight != '0))
        else $error("result presented with no beat in flight");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> ((r_flight == W_FLIGHT'(PIPE_DEPTH)) && o_out.valid && !o_out.ready))
        else $error("input stalled while the pipeline still has room");

endmodule

// File: hw/rtl/asec_front.sv
module asec_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  asec_pkg::t_cfg  i_cfg,
    input  logic            i_hist_clr,
    input  logic            i_valid,
    output logic            o_ready,
    input  asec_pkg::t_item i_item,
    output logic            o_valid,
    input  logic            i_ready,
    output asec_pkg::t_front o_data
);
    import asec_pkg::*;

    logic [W_TVAL-1:0]   r_mem [TABLE_DEPTH];

    logic                r_a_valid;
    logic [W_CMD-1:0]    r_a_cmd;
    logic [W_SAMPLE-1:0] r_a_sample;
    logic [W_TVAL-1:0]   r_a_tbl;

    logic [W_LEVEL-1:0]  r_peak;
    logic [W_LEVEL-1:0]  n_peak;
    logic [W_SAMPLE-1:0] r_x1;
    logic [W_SAMPLE-1:0] r_x2;

    logic                r_b_valid;
    t_front              r_b;

    logic                w_accept;
    logic                w_a_adv;
    logic [TBL_XW-1:0]   w_rd_x;
    logic [TBL_XW-1:0]   w_wr_x;
    logic                w_rd_in;
    logic                w_wr_in;
    logic [W_LEVEL-1:0]  w_level;
    logic                w_proc;
    logic                w_shelv;
    logic [W_SAMPLE-1:0] w_x;
    logic [W_COEF-1:0]   w_p0;
    logic [W_COEF-1:0]   w_p1;
    logic [W_COEF-1:0]   w_p2;

    assign w_a_adv  = r_a_valid && (!r_b_valid || i_ready);
    assign o_ready  = !r_a_valid || w_a_adv;
    assign w_accept = i_valid && o_ready;

    // table read is issued on the accepting edge, so the data lands with the beat
    assign w_rd_x  = TBL_XW'(i_item.sample >> SHAPE_SHIFT);
    assign w_wr_x  = TBL_XW'(i_item.table_index);
    assign w_rd_in = w_rd_x < TBL_XW'(TABLE_DEPTH);
    assign w_wr_in = w_wr_x < TBL_XW'(TABLE_DEPTH);

    always_ff @(posedge i_clk) begin
        if (w_accept && (i_item.command == CMD_TBL_WRITE) && w_wr_in) begin
            r_mem[w_wr_x[TBL_AW-1:0]] <= i_item.table_value;
        end
        if (w_accept) begin
            if (w_rd_in) begin
                r_a_tbl <= r_mem[w_rd_x[TBL_AW-1:0]];
            end else begin
                r_a_tbl <= '0;
            end
        end
    end

    assign w_level = r_a_sample[W_SAMPLE-1:SHAPE_SHIFT];
    assign w_proc  = (r_a_cmd == CMD_PROCESS);
    assign w_shelv = w_proc && i_cfg.shelv;
    assign w_x     = i_cfg.distort ? (W_SAMPLE'(r_a_tbl) << SHAPE_SHIFT) : r_a_sample;

    always_comb begin
        n_peak = r_peak;
        unique case (r_a_cmd)
            CMD_PROCESS: begin
                if (w_level > r_peak) begin
                    n_peak = w_level;
                end
            end
            CMD_PEAK_CLEAR: n_peak = '0;
            default: ;
        endcase
    end

    // feedforward products, low 32 bits
    assign w_p0 = i_cfg.b0 * W_COEF'(w_x);
    assign w_p1 = i_cfg.b1 * W_COEF'(r_x1);
    assign w_p2 = i_cfg.b2 * W_COEF'(r_x2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_peak    <= '0;
            r_x1      <= '0;
            r_x2      <= '0;
        end else begin
            if (w_accept) begin
                r_a_valid <= 1'b1;
            end else if (w_a_adv) begin
                r_a_valid <= 1'b0;
            end
            if (w_a_adv) begin
                r_b_valid <= 1'b1;
            end else if (i_ready) begin
                r_b_valid <= 1'b0;
            end
            if (w_a_adv) begin
                r_peak <= n_peak;
            end
            if (i_hist_clr) begin
                r_x1 <= '0;
                r_x2 <= '0;
            end else if (w_a_adv && w_shelv) begin
                r_x2 <= r_x1;
                r_x1 <= w_x;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a_cmd    <= i_item.command;
            r_a_sample <= i_item.sample;
        end
        if (w_a_adv) begin
            r_b.ctl.proc  <= w_proc;
            r_b.ctl.shelv <= w_shelv;
            r_b.ctl.x     <= w_x;
            r_b.ctl.peak  <= n_peak;
            r_b.p0        <= w_p0;
            r_b.p1        <= w_p1;
            r_b.p2        <= w_p2;
        end
    end

    assign o_valid = r_b_valid;
    assign o_data  = r_b;

endmodule

// File: hw/rtl/asec_biquad.sv
module asec_biquad (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  asec_pkg::t_cfg   i_cfg,
    input  logic             i_hist_clr,
    input  logic             i_valid,
    output logic             o_ready,
    input  asec_pkg::t_front i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output asec_pkg::t_fb    o_data
);
    import asec_pkg::*;

    logic              r_c_valid;
    t_ctl              r_c_ctl;
    logic [W_COEF-1:0] r_c_f;
    logic [W_COEF-1:0] r_c_m2;

    logic              r_d_valid;
    t_fb               r_d;

    logic [W_COEF-1:0] r_y1;
    logic [W_COEF-1:0] r_y2;

    logic              w_accept;
    logic              w_c_adv;
    logic [W_COEF-1:0] w_y2_sel;
    logic [W_COEF-1:0] w_f;
    logic [W_COEF-1:0] w_m2;
    logic [W_COEF-1:0] w_m1;
    logic [W_COEF-1:0] w_y;

    assign w_c_adv  = r_c_valid && (!r_d_valid || i_ready);
    assign o_ready  = !r_c_valid || w_c_adv;
    assign w_accept = i_valid && o_ready;

    // y[n-2] for the incoming beat: if a filtering beat sits in the loop stage it is
    // about to shift r_y1 into the y[n-2] slot
    assign w_y2_sel = (r_c_valid && r_c_ctl.shelv) ? r_y1 : r_y2;
    assign w_f      = i_data.p0 + i_data.p1 + i_data.p2;
    assign w_m2     = i_cfg.a2 * w_y2_sel;

    // recursive part: one multiply by y[n-1] per beat
    assign w_m1 = i_cfg.a1 * r_y1;
    assign w_y  = (r_c_f - r_c_m2) - w_m1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_y1      <= '0;
            r_y2      <= '0;
        end else begin
            if (w_accept) begin
                r_c_valid <= 1'b1;
            end else if (w_c_adv) begin
                r_c_valid <= 1'b0;
            end
            if (w_c_adv) begin
                r_d_valid <= 1'b1;
            end else if (i_ready) begin
                r_d_valid <= 1'b0;
            end
            if (i_hist_clr) begin
                r_y1 <= '0;
                r_y2 <= '0;
            end else if (w_c_adv && r_c_ctl.shelv) begin
                r_y2 <= r_y1;
                r_y1 <= w_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_c_ctl <= i_data.ctl;
            r_c_f   <= w_f;
            r_c_m2  <= w_m2;
        end
        if (w_c_adv) begin
            r_d.ctl <= r_c_ctl;
            r_d.y   <= w_y;
        end
    end

    assign o_valid = r_d_valid;
    assign o_data  = r_d;

endmodule

// File: hw/rtl/asec_scale.sv
module asec_scale (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  asec_pkg::t_fb                 i_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [asec_pkg::W_SAMPLE-1:0] o_dac,
    output logic [asec_pkg::W_LEVEL-1:0]  o_peak
);
    import asec_pkg::*;

    logic                r_e_valid;
    t_ctl                r_e_ctl;
    logic [W_SAMPLE-1:0] r_e_q;
    logic                r_e_neg;
    logic                r_e_big;

    logic                r_o_valid;
    logic [W_SAMPLE-1:0] r_o_dac;
    logic [W_LEVEL-1:0]  r_o_peak;

    logic                w_accept;
    logic                w_e_adv;
    logic                w_neg;
    logic                w_big;
    logic [W_PROD-1:0]   w_prod;
    logic [W_SAMPLE-1:0] w_result;
    logic [W_SAMPLE-1:0] w_dac;

    assign w_e_adv  = r_e_valid && (!r_o_valid || i_ready);
    assign o_ready  = !r_e_valid || w_e_adv;
    assign w_accept = i_valid && o_ready;

    // negative y clamps to zero; only 0 <= y < 4096*3270 needs the quotient,
    // taken as a multiply by the rounded-up reciprocal
    assign w_neg  = i_data.y[W_COEF-1];
    assign w_big  = !w_neg && (i_data.y >= W_COEF'(SAT_LIMIT));
    assign w_prod = W_PROD'(i_data.y[W_SAT-1:0]) * W_PROD'(RECIP);

    always_comb begin
        priority if (!r_e_ctl.shelv) begin
            w_result = r_e_ctl.x;
        end else if (r_e_neg) begin
            w_result = '0;
        end else if (r_e_big) begin
            w_result = W_SAMPLE'(DAC_MAX);
        end else begin
            w_result = r_e_q;
        end
    end

    assign w_dac = r_e_ctl.proc ? w_result : r_o_dac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_o_dac   <= '0;
        end else begin
            if (w_accept) begin
                r_e_valid <= 1'b1;
            end else if (w_e_adv) begin
                r_e_valid <= 1'b0;
            end
            if (w_e_adv) begin
                r_o_valid <= 1'b1;
                r_o_dac   <= w_dac;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_e_ctl <= i_data.ctl;
            r_e_q   <= w_prod[RECIP_SHIFT +: W_SAMPLE];
            r_e_neg <= w_neg;
            r_e_big <= w_big;
        end
        if (w_e_adv) begin
            r_o_peak <= r_e_ctl.peak;
        end
    end

    assign o_valid = r_o_valid;
    assign o_dac   = r_o_dac;
    assign o_peak  = r_o_peak;

endmodule

// File: dv/tb_audio_sample_effect_chain_unit.sv
`timescale 1ns / 1ps

module tb_audio_sample_effect_chain_unit;
    import asec_pkg::*;

    localparam logic [W_CMD-1:0] CMD_UNUSED = 2'd3;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned RAND_PHASES  = 11;
    localparam int unsigned PHASE_BEATS  = 148;

    typedef struct {
        logic [W_SAMPLE-1:0] dac;
        logic [W_LEVEL-1:0]  peak;
    } t_dac_peak;

    logic i_clk;
    logic i_rst_n;

    asec_in_if  in_bus ();
    asec_out_if out_bus ();
    asec_cfg_if cfg_bus ();

    audio_sample_effect_chain_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .i_cfg   (cfg_bus)
    );

    // shadow of the effect chain
    logic [W_TVAL-1:0]   shape_mem [TABLE_DEPTH];
    logic [W_LEVEL-1:0]  sh_peak;
    logic [W_COEF-1:0]   sh_x1, sh_x2, sh_y1, sh_y2;
    logic [W_SAMPLE-1:0] sh_held;
    logic                sh_dist, sh_shelv;
    logic [W_COEF-1:0]   sh_b0, sh_b1, sh_b2, sh_a1, sh_a2;

    t_item     sample_cmd_q [$];
    t_dac_peak dac_peak_q [$];

    // which table entries the stimulus has already loaded
    bit                 filled [TABLE_DEPTH];
    logic [W_LEVEL-1:0] filled_lvls [$];

    bit          gapless;
    int unsigned gap_cnt;
    int unsigned stall_cnt;
    int unsigned errors;
    int unsigned n_proc, n_twr, n_clr, n_unused, n_checked, n_settings;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (gapless) return 0;
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic void clear_history();
        sh_x1 = '0;
        sh_x2 = '0;
        sh_y1 = '0;
        sh_y2 = '0;
    endfunction

    function automatic void run_chain(input t_item it);
        logic [W_LEVEL-1:0] lvl;
        logic [W_COEF-1:0]  x, y, mag, q;
        t_dac_peak          res;
        lvl = it.sample[W_SAMPLE-1:SHAPE_SHIFT];
        case (it.command)
            CMD_PROCESS: begin
                n_proc++;
                if (lvl > sh_peak) sh_peak = lvl;
                x = W_COEF'(it.sample);
                if (sh_dist)
                    x = (lvl < TABLE_DEPTH) ? (W_COEF'(shape_mem[lvl]) << SHAPE_SHIFT) : '0;
                if (sh_shelv) begin
                    y = sh_b0 * x + sh_b1 * sh_x1 + sh_b2 * sh_x2 - sh_a1 * sh_y1 - sh_a2 * sh_y2;
                    sh_x2 = sh_x1;
                    sh_x1 = x;
                    sh_y2 = sh_y1;
                    sh_y1 = y;
                    mag = y[W_COEF-1] ? -y : y;
                    q = mag / SCALE_DIV;
                    // negative y clamps to zero whatever its magnitude
                    if (y[W_COEF-1])  sh_held = '0;
                    else if (q > DAC_MAX) sh_held = W_SAMPLE'(DAC_MAX);
                    else sh_held = q[W_SAMPLE-1:0];
                end else begin
                    sh_held = (x > DAC_MAX) ? W_SAMPLE'(DAC_MAX) : x[W_SAMPLE-1:0];
                end
            end
            CMD_TBL_WRITE: begin
                n_twr++;
                if (it.table_index < TABLE_DEPTH) shape_mem[it.table_index] = it.table_value;
            end
            CMD_PEAK_CLEAR: begin
                n_clr++;
                sh_peak = '0;
            end
            default: n_unused++;
        endcase
        res.dac  = sh_held;
        res.peak = sh_peak;
        dac_peak_q.push_back(res);
    endfunction

    // driver
    always @(posedge i_clk) begin : drv
        t_item it;
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
            gap_cnt = 0;
        end else if (!in_bus.valid || in_bus.ready) begin
            if (gap_cnt > 0) begin
                gap_cnt--;
                in_bus.valid <= 1'b0;
            end else if (sample_cmd_q.size() > 0) begin
                it = sample_cmd_q.pop_front();
                in_bus.command     <= it.command;
                in_bus.sample      <= it.sample;
                in_bus.table_index <= it.table_index;
                in_bus.table_value <= it.table_value;
                in_bus.valid       <= 1'b1;
                gap_cnt = pick_gap();
            end else begin
                in_bus.valid <= 1'b0;
            end
        end
    end

    // monitor: predicts on input beats, checks output beats, throttles ready
    always @(posedge i_clk) begin : mon
        t_item     it;
        t_dac_peak want;
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
            stall_cnt = 0;
        end else begin
            if (in_bus.valid && in_bus.ready) begin
                it.command     = in_bus.command;
                it.sample      = in_bus.sample;
                it.table_index = in_bus.table_index;
                it.table_value = in_bus.table_value;
                run_chain(it);
            end
            if (out_bus.valid && out_bus.ready) begin
                if (dac_peak_q.size() == 0) begin
                    $error("unexpected result beat: dac_value=%0d peak_level=%0d",
                           out_bus.dac_value, out_bus.peak_level);
                    errors++;
                end else begin
                    want = dac_peak_q.pop_front();
                    n_checked++;
                    if (out_bus.dac_value !== want.dac) begin
                        $error("dac_value mismatch: expected %0d, actual %0d",
                               want.dac, out_bus.dac_value);
                        errors++;
                    end
                    if (out_bus.peak_level !== want.peak) begin
                        $error("peak_level mismatch: expected %0d, actual %0d",
                               want.peak, out_bus.peak_level);
                        errors++;
                    end
                end
            end
            if (stall_cnt > 0) begin
                stall_cnt--;
                out_bus.ready <= 1'b0;
            end else begin
                out_bus.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall_cnt = pick_gap();
            end
        end
    end

    function automatic t_item beat_of(input logic [W_CMD-1:0] cmd, input int unsigned smp,
                                      input int unsigned idx, input int unsigned val);
        t_item it;
        it.command     = cmd;
        it.sample      = W_SAMPLE'(smp);
        it.table_index = W_LEVEL'(idx);
        it.table_value = W_TVAL'(val);
        return it;
    endfunction

    function automatic void queue_beat(input t_item it);
        if (it.command == CMD_TBL_WRITE && it.table_index < TABLE_DEPTH
            && !filled[it.table_index]) begin
            filled[it.table_index] = 1'b1;
            filled_lvls.push_back(it.table_index);
        end
        sample_cmd_q.push_back(it);
    endfunction

    function automatic t_item make_item(input bit dist_on);
        t_item              it;
        int unsigned        r;
        logic [W_LEVEL-1:0] lvl;
        it = beat_of(CMD_PROCESS, $urandom, $urandom, $urandom);
        r = $urandom_range(0, 99);
        if (r < 72) begin
            lvl = it.sample[W_SAMPLE-1:SHAPE_SHIFT];
            // with the shaper on, only look up entries already loaded
            if (dist_on && lvl < TABLE_DEPTH && !filled[lvl]) begin
                lvl = filled_lvls[$urandom_range(0, filled_lvls.size() - 1)];
                it.sample = {lvl, 2'($urandom)};
            end
        end else if (r < 86) begin
            it.command = CMD_TBL_WRITE;
        end else if (r < 95) begin
            it.command = CMD_PEAK_CLEAR;
        end else begin
            it.command = CMD_UNUSED;
        end
        return it;
    endfunction

    // wait for the chain to drain, then let the clock run on idle
    task automatic settle();
        while (sample_cmd_q.size() != 0 || in_bus.valid || dac_peak_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [W_COEF-1:0] data);
        @(posedge i_clk);
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        cfg_bus.valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        case (idx)
            CFG_DIST:  sh_dist  = data[0];
            CFG_SHELV: sh_shelv = data[0];
            CFG_B0: begin sh_b0 = data; clear_history(); end
            CFG_B1: begin sh_b1 = data; clear_history(); end
            CFG_B2: begin sh_b2 = data; clear_history(); end
            CFG_A1: begin sh_a1 = data; clear_history(); end
            CFG_A2: begin sh_a2 = data; clear_history(); end
            default: ;
        endcase
    endtask

    task automatic apply_settings(input bit distort, input bit shelv, input bit coefs,
                                  input logic [W_COEF-1:0] b0, input logic [W_COEF-1:0] b1,
                                  input logic [W_COEF-1:0] b2, input logic [W_COEF-1:0] a1,
                                  input logic [W_COEF-1:0] a2);
        settle();
        // upper bits of the enable words are don't-care
        write_reg(CFG_DIST,  {31'($urandom), distort});
        write_reg(CFG_SHELV, {31'($urandom), shelv});
        if (coefs) begin
            write_reg(CFG_B0, b0);
            write_reg(CFG_B1, b1);
            write_reg(CFG_B2, b2);
            write_reg(CFG_A1, a1);
            write_reg(CFG_A2, a2);
        end
        n_settings++;
    endtask

    function automatic logic [W_COEF-1:0] pick_extreme();
        case ($urandom_range(0, 3))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            default: return '0;
        endcase
    endfunction

    task automatic random_settings(input int unsigned phase);
        logic [W_COEF-1:0] c [5];
        bit                distort, shelv, coefs;
        int unsigned       style;
        style   = $urandom_range(0, 3);
        distort = $urandom_range(0, 1);
        shelv   = (phase % 3 != 2) ? 1'b1 : 1'($urandom_range(0, 1));
        coefs   = (phase == 0) || ($urandom_range(0, 2) != 0);
        case (style)
            0: begin
                c[0] = $urandom_range(0, 6540);
                c[1] = int'($urandom_range(0, 6540)) - 3270;
                c[2] = int'($urandom_range(0, 6540)) - 3270;
                c[3] = int'($urandom_range(0, 2)) - 1;
                c[4] = int'($urandom_range(0, 2)) - 1;
            end
            1: begin
                for (int i = 0; i < 3; i++) c[i] = int'($urandom_range(0, 40000)) - 20000;
                c[3] = '0;
                c[4] = '0;
            end
            2: for (int i = 0; i < 5; i++) c[i] = $urandom;
            default: for (int i = 0; i < 5; i++) c[i] = pick_extreme();
        endcase
        gapless = (phase % 4 == 3);
        apply_settings(distort, shelv, coefs, c[0], c[1], c[2], c[3], c[4]);
    endtask

    initial begin
        #10ms;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        i_rst_n             = 1'b0;
        in_bus.valid        = 1'b0;
        in_bus.command      = CMD_PROCESS;
        in_bus.sample       = '0;
        in_bus.table_index  = '0;
        in_bus.table_value  = '0;
        out_bus.ready       = 1'b0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.index       = CFG_DIST;
        cfg_bus.data        = '0;
        gapless             = 1'b0;
        errors              = 0;
        sh_peak  = '0;
        sh_held  = '0;
        sh_dist  = 1'b0;
        sh_shelv = 1'b0;
        sh_b0 = '0; sh_b1 = '0; sh_b2 = '0; sh_a1 = '0; sh_a2 = '0;
        clear_history();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: plain pass-through
        queue_beat(beat_of(CMD_PROCESS, 0, 0, 0));
        queue_beat(beat_of(CMD_PROCESS, 4095, 1023, 1023));
        queue_beat(beat_of(CMD_UNUSED, 2730, 341, 682));
        queue_beat(beat_of(CMD_PEAK_CLEAR, 1365, 682, 341));
        queue_beat(beat_of(CMD_PROCESS, 1, 0, 0));
        queue_beat(beat_of(CMD_TBL_WRITE, 0, 0, 1023));
        queue_beat(beat_of(CMD_TBL_WRITE, 4095, 1023, 0));
        queue_beat(beat_of(CMD_TBL_WRITE, 0, 512, 341));
        queue_beat(beat_of(CMD_TBL_WRITE, 0, 1, 682));

        // shaper only
        apply_settings(1'b1, 1'b0, 1'b0, '0, '0, '0, '0, '0);
        queue_beat(beat_of(CMD_PROCESS, 4095, 0, 0));
        queue_beat(beat_of(CMD_PROCESS, 0, 0, 0));
        queue_beat(beat_of(CMD_PROCESS, 2050, 0, 0));
        queue_beat(beat_of(CMD_PROCESS, 7, 0, 0));

        // unity-gain biquad
        apply_settings(1'b0, 1'b1, 1'b1, SCALE_DIV, '0, '0, '0, '0);
        queue_beat(beat_of(CMD_PROCESS, 4095, 0, 0));
        queue_beat(beat_of(CMD_PROCESS, 100, 0, 0));

        // coefficient extremes, shaper in front
        apply_settings(1'b1, 1'b1, 1'b1, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                       32'h8000_0000, 32'h7fff_ffff);
        queue_beat(beat_of(CMD_PROCESS, 0, 0, 0));
        queue_beat(beat_of(CMD_PROCESS, 4095, 0, 0));
        queue_beat(beat_of(CMD_PROCESS, 7, 0, 0));
        queue_beat(beat_of(CMD_PROCESS, 2050, 0, 0));
        queue_beat(beat_of(CMD_PROCESS, 0, 0, 0));

        // negative gain clamps low
        apply_settings(1'b0, 1'b1, 1'b1, -SCALE_DIV, '0, '0, '0, '0);
        queue_beat(beat_of(CMD_PROCESS, 4095, 0, 0));
        queue_beat(beat_of(CMD_PROCESS, 0, 0, 0));

        // double gain clamps high
        apply_settings(1'b0, 1'b1, 1'b1, 2 * SCALE_DIV, '0, '0, '0, '0);
        queue_beat(beat_of(CMD_PROCESS, 3000, 0, 0));

        for (int unsigned p = 0; p < RAND_PHASES; p++) begin
            random_settings(p);
            for (int unsigned n = 0; n < PHASE_BEATS; n++) queue_beat(make_item(sh_dist));
        end

        settle();
        $display("Run covered %0d process, %0d table-write, %0d peak-clear, %0d unused beats",
                 n_proc, n_twr, n_clr, n_unused);
        $display("%0d results checked over %0d register settings", n_checked, n_settings);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
